// File: rtl/core/tcse_pkg.sv
`timescale 1ns / 1ps
// tcse_pkg: shared types and constants of the text console scroll engine
// depends on nothing; used by every other file of the block

package tcse_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;
   localparam int QUEUE_DEPTH = 2;

   localparam int CMD_W     = 2;
   localparam int CHAR_W    = 8;
   localparam int COLOR_W   = 8;
   localparam int CELL_W    = 16;
   localparam int COL_IN_W  = 7;
   localparam int ROW_IN_W  = 5;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'h0020;
   localparam logic [CELL_W-1:0]  RESET_CELL   = 16'h0720;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } back_state_type;

   // one queued job for the back end, apart from the cell address
   typedef struct packed {
      op_type                op;
      logic                  scroll;
      logic [CELL_W-1:0]     data;
      logic [ROW_IN_W-1:0]   cur_row;
      logic [COL_IN_W-1:0]   cur_col;
   } entry_type;

endpackage

// File: rtl/core/tcse_if.sv
`timescale 1ns / 1ps
// tcse_req_if and tcse_rsp_if: valid/ready channels of the console engine
// depends on tcse_pkg for the field widths

interface tcse_req_if;
   import tcse_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [CHAR_W-1:0]   char_code;
   logic [COLOR_W-1:0]  cell_color;
   logic [COL_IN_W-1:0] column;
   logic [ROW_IN_W-1:0] row;

   modport source (output valid, cmd, char_code, cell_color, column, row, input ready);
   modport sink   (input valid, cmd, char_code, cell_color, column, row, output ready);
endinterface

interface tcse_rsp_if;
   import tcse_pkg::*;

   logic                valid;
   logic                ready;
   logic [CELL_W-1:0]   cell_data;
   logic [ROW_IN_W-1:0] cursor_row;
   logic [COL_IN_W-1:0] cursor_column;

   modport source (output valid, cell_data, cursor_row, cursor_column, input ready);
   modport sink   (input valid, cell_data, cursor_row, cursor_column, output ready);
endinterface

// File: rtl/core/tcse_front.sv
`timescale 1ns / 1ps
// tcse_front: accepts items, keeps cursor, top-row pointer and text colour,
// and turns each item into a back-end job. depends on tcse_pkg, tcse_req_if

module tcse_front #(
   parameter int  COLUMNS = tcse_pkg::DEF_COLUMNS,
   parameter int  ROWS    = tcse_pkg::DEF_ROWS,
   localparam int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
   input  logic                      clock,
   input  logic                      reset,
   tcse_req_if.sink                  req,
   input  logic                      csr_wr_en,
   input  logic [tcse_pkg::COLOR_W-1:0] csr_wr_data,
   input  logic                      mem_ready,
   input  logic                      q_ready,
   output logic                      q_push,
   output tcse_pkg::entry_type       q_ctl,
   output logic [ADDR_W-1:0]         q_addr
);
   import tcse_pkg::*;

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);

   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   top_ff, top_in;
   logic [COLOR_W-1:0] text_color_ff;

   logic             accept;
   logic             in_range;
   logic             advance;
   logic [ROW_W-1:0] lrow;
   logic [COL_W-1:0] lcol;
   logic [ROW_W:0]   psum;
   logic [ROW_W-1:0] prow;

   assign req.ready = q_ready && mem_ready;
   assign accept    = req.valid && req.ready;
   assign q_push    = accept;
   assign in_range  = (int'(req.column) < COLUMNS) && (int'(req.row) < ROWS);

   always_comb begin
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      advance      = 1'b0;
      lrow         = cur_row_ff;
      lcol         = cur_col_ff;
      q_ctl        = '0;
      q_ctl.op     = OP_NONE;
      unique case (cmd_type'(req.cmd))
         CMD_PUT: begin
            if (req.char_code == NEWLINE_CODE) begin
               cur_col_in = '0;
               advance    = 1'b1;
            end else begin
               q_ctl.op   = OP_WRITE;
               q_ctl.data = {text_color_ff, req.char_code};
               if (cur_col_ff == COL_W'(COLUMNS - 1)) begin
                  cur_col_in = '0;
                  advance    = 1'b1;
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
         end
         CMD_READ: begin
            lrow = ROW_W'(req.row);
            lcol = COL_W'(req.column);
            if (in_range) begin
               q_ctl.op = OP_READ;
            end
         end
         CMD_WRITE: begin
            lrow = ROW_W'(req.row);
            lcol = COL_W'(req.column);
            if (in_range) begin
               q_ctl.op   = OP_WRITE;
               q_ctl.data = {req.cell_color, req.char_code};
            end
         end
         default: begin
         end
      endcase
      // past the last row: the screen scrolls, cursor stays on the last row
      if (advance) begin
         if (cur_row_ff == ROW_W'(ROWS - 1)) begin
            q_ctl.scroll = 1'b1;
            top_in = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
         end else begin
            cur_row_in = cur_row_ff + 1'b1;
         end
      end
      q_ctl.cur_row = ROW_IN_W'(cur_row_in);
      q_ctl.cur_col = COL_IN_W'(cur_col_in);
      // logical row to stored row through the top-row pointer
      psum = {1'b0, lrow} + {1'b0, top_ff};
      if (int'(psum) >= ROWS) begin
         psum = psum - (ROW_W + 1)'(ROWS);
      end
      prow   = ROW_W'(psum);
      q_addr = ADDR_W'(int'(prow) * COLUMNS + int'(lcol));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         top_ff     <= '0;
      end else if (accept) begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         top_ff     <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_wr_en) begin
         text_color_ff <= csr_wr_data;
      end
   end

endmodule

// File: rtl/core/tcse_queue.sv
`timescale 1ns / 1ps
// tcse_queue: short first-in first-out queue of jobs between front and back
// depends on tcse_pkg for the default depth

module tcse_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tcse_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   import tcse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (int'(count_ff) < DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/tcse_back.sv
`timescale 1ns / 1ps
// tcse_back: screen memory, clearing pass, line blanking on scroll and the
// result register. depends on tcse_pkg, tcse_rsp_if

module tcse_back #(
   parameter int  COLUMNS = tcse_pkg::DEF_COLUMNS,
   parameter int  ROWS    = tcse_pkg::DEF_ROWS,
   localparam int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tcse_pkg::entry_type q_ctl,
   input  logic [ADDR_W-1:0]   q_addr,
   output logic                q_pop,
   output logic                mem_ready,
   tcse_rsp_if.source          rsp
);
   import tcse_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   back_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [ADDR_W:0]     base_sum;
   logic [ROW_IN_W-1:0] pend_row_ff, pend_row_in;
   logic [COL_IN_W-1:0] pend_col_ff, pend_col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [ROW_IN_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_IN_W-1:0] rsp_col_ff, rsp_col_in;
   logic                rsp_free;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [CELL_W-1:0]   mem_wdata;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign mem_ready = (state_ff != ST_CLEAR);
   assign base_sum  = {1'b0, base_ff} + (ADDR_W + 1)'(COLUMNS);

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.cell_data     = rsp_data_ff;
   assign rsp.cursor_row    = rsp_row_ff;
   assign rsp.cursor_column = rsp_col_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = q_addr;
      mem_wdata    = q_ctl.data;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = RESET_CELL;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid && rsp_free) begin
               q_pop       = 1'b1;
               mem_we      = (q_ctl.op == OP_WRITE);
               pend_row_in = q_ctl.cur_row;
               pend_col_in = q_ctl.cur_col;
               if (q_ctl.op == OP_READ) begin
                  state_in = ST_READ;
               end else if (q_ctl.scroll) begin
                  cnt_in   = '0;
                  state_in = ST_SCROLL;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_row_in   = q_ctl.cur_row;
                  rsp_col_in   = q_ctl.cur_col;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data_ff;
            rsp_row_in   = pend_row_ff;
            rsp_col_in   = pend_col_ff;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            // the stored row under the old top becomes the new bottom row
            mem_we    = 1'b1;
            mem_waddr = base_ff + cnt_ff;
            mem_wdata = BLANK_CELL;
            if (cnt_ff == ADDR_W'(COLUMNS - 1)) begin
               cnt_in       = '0;
               base_in      = (int'(base_sum) >= CELLS) ? '0 : ADDR_W'(base_sum);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_row_in   = pend_row_ff;
               rsp_col_in   = pend_col_ff;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      rsp_data_ff <= rsp_data_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[q_addr];
   end

endmodule

// File: rtl/core/text_console_scroll_engine_top.sv
`timescale 1ns / 1ps
// text_console_scroll_engine_top: text console with cursor and scrolling
// depends on tcse_pkg, tcse_if, tcse_front, tcse_queue, tcse_back
//
//   port      dir   handshake           carries
//   req_chan  in    valid/ready         cmd, char_code, cell_color, column, row
//   rsp_chan  out   valid/ready         cell_data, cursor_row, cursor_column
//   csr_*     in    write enable only   text_color
//
// a put or raw write is written to memory straight from idle, a read goes
// through the registered memory read, a scroll blanks the new bottom line.
// after reset the screen memory is cleared cell by cell with req_chan.ready
// low. the front can run up to the queue depth ahead of the back end; a
// stalled result holds the back end.

module text_console_scroll_engine_top #(
   parameter int COLUMNS = tcse_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcse_pkg::DEF_ROWS
) (
   input  logic                         clock,
   input  logic                         reset,
   tcse_req_if.sink                     req_chan,
   tcse_rsp_if.source                   rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [tcse_pkg::COLOR_W-1:0] csr_wr_data
);
   import tcse_pkg::*;

   localparam int ADDR_W = $clog2(COLUMNS * ROWS);
   localparam int JOB_W  = $bits(entry_type) + ADDR_W;

   logic              push, push_ready, pop, pop_valid, mem_ready;
   entry_type         push_ctl, pop_ctl;
   logic [ADDR_W-1:0] push_addr, pop_addr;
   logic [JOB_W-1:0]  pop_job;

   tcse_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_ready   (mem_ready),
      .q_ready     (push_ready),
      .q_push      (push),
      .q_ctl       (push_ctl),
      .q_addr      (push_addr)
   );

   tcse_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_ctl, push_addr}),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_job)
   );

   assign pop_ctl  = entry_type'(pop_job[JOB_W-1:ADDR_W]);
   assign pop_addr = pop_job[ADDR_W-1:0];

   tcse_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_ctl     (pop_ctl),
      .q_addr    (pop_addr),
      .q_pop     (pop),
      .mem_ready (mem_ready),
      .rsp       (rsp_chan)
   );

endmodule

// File: sim/tb_text_console_scroll_engine_top.sv
`timescale 1ns / 1ps
// tb_text_console_scroll_engine_top: self-checking bench for the text console engine
// depends on tcse_pkg, tcse_if and text_console_scroll_engine_top from the rtl tree

module tb_text_console_scroll_engine_top;
   import tcse_pkg::*;

   localparam int COLUMNS      = DEF_COLUMNS;
   localparam int ROWS         = DEF_ROWS;
   localparam int SCREEN_CELLS = COLUMNS * ROWS;
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASES       = 5;
   localparam int SETTLE       = COLUMNS + 20;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 250;
   localparam int CYCLE_LIMIT  = 600000;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOR_W-1:0]  cell_color;
      logic [COL_IN_W-1:0] column;
      logic [ROW_IN_W-1:0] row;
   } command_type;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_data;
      logic [ROW_IN_W-1:0] cursor_row;
      logic [COL_IN_W-1:0] cursor_column;
   } status_type;

   class screen_scoreboard;
      logic [CELL_W-1:0]  cells [SCREEN_CELLS];
      int unsigned        cur_row;
      int unsigned        cur_col;
      logic [COLOR_W-1:0] text_color;
      status_type         awaited_status [$];
      int unsigned        failures;
      int unsigned        checked;
      int unsigned        scrolls;

      function new();
         foreach (cells[i]) cells[i] = RESET_CELL;
         cur_row    = 0;
         cur_col    = 0;
         text_color = RESET_COLOR;
         failures   = 0;
         checked    = 0;
         scrolls    = 0;
      endfunction

      function void set_text_color(logic [COLOR_W-1:0] value);
         text_color = value;
      endfunction

      function void advance_line();
         cur_row++;
         if (cur_row >= ROWS) begin
            cur_row = ROWS - 1;
            for (int i = COLUMNS; i < SCREEN_CELLS; i++) cells[i - COLUMNS] = cells[i];
            for (int i = SCREEN_CELLS - COLUMNS; i < SCREEN_CELLS; i++) cells[i] = BLANK_CELL;
            scrolls++;
         end
      endfunction

      function void put_char(logic [CHAR_W-1:0] ch);
         if (ch == NEWLINE_CODE) begin
            cur_col = 0;
            advance_line();
            return;
         end
         cells[cur_row * COLUMNS + cur_col] = {text_color, ch};
         cur_col++;
         if (cur_col >= COLUMNS) begin
            cur_col = 0;
            advance_line();
         end
      endfunction

      // updates the screen copy for one accepted item and queues the status it causes
      function void note_command(command_type c);
         status_type st;
         bit         in_range;
         int         idx;
         in_range = (c.column < COLUMNS) && (c.row < ROWS);
         idx = int'(c.row) * COLUMNS + int'(c.column);
         st.cell_data = '0;
         case (c.cmd)
            CMD_PUT: put_char(c.char_code);
            CMD_READ: if (in_range) st.cell_data = cells[idx];
            CMD_WRITE: if (in_range) cells[idx] = {c.cell_color, c.char_code};
            default: ;
         endcase
         st.cursor_row    = cur_row[ROW_IN_W-1:0];
         st.cursor_column = cur_col[COL_IN_W-1:0];
         awaited_status.push_back(st);
      endfunction

      function void check_status(status_type got);
         status_type want;
         if (awaited_status.size() == 0) begin
            $error("result with nothing awaited: cell_data %h row %0d column %0d",
                   got.cell_data, got.cursor_row, got.cursor_column);
            failures++;
            return;
         end
         want = awaited_status.pop_front();
         checked++;
         if (got.cell_data !== want.cell_data) begin
            $error("cell_data: expected %h, actual %h", want.cell_data, got.cell_data);
            failures++;
         end
         if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row: expected %0d, actual %0d", want.cursor_row, got.cursor_row);
            failures++;
         end
         if (got.cursor_column !== want.cursor_column) begin
            $error("cursor_column: expected %0d, actual %0d",
                   want.cursor_column, got.cursor_column);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COLOR_W-1:0] csr_wr_data;

   tcse_req_if req_chan ();
   tcse_rsp_if rsp_chan ();

   text_console_scroll_engine_top #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   screen_scoreboard sb = new();
   bit          burst_mode = 1'b0;
   int unsigned items_sent = 0;
   int unsigned colours_used = 1;
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // result side: random stalls plus one long hold-off so the input backs up
   initial begin
      int unsigned stall_left;
      bit          long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && sb.checked >= HOLD_AFTER) begin
            stall_left     = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      status_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.cell_data     = rsp_chan.cell_data;
         got.cursor_row    = rsp_chan.cursor_row;
         got.cursor_column = rsp_chan.cursor_column;
         sb.check_status(got);
      end
   end

   function automatic command_type make_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                                logic [COLOR_W-1:0] colour,
                                                logic [COL_IN_W-1:0] col,
                                                logic [ROW_IN_W-1:0] row);
      command_type c;
      c.cmd        = cmd;
      c.char_code  = ch;
      c.cell_color = colour;
      c.column     = col;
      c.row        = row;
      return c;
   endfunction

   function automatic command_type random_command();
      command_type c;
      int unsigned pick;
      int unsigned aim;
      pick = $urandom_range(0, 99);
      c.cmd        = CMD_PUT;
      c.char_code  = CHAR_W'($urandom_range(0, 255));
      c.cell_color = COLOR_W'($urandom_range(0, 255));
      c.column     = COL_IN_W'($urandom_range(0, COLUMNS - 1));
      c.row        = ROW_IN_W'($urandom_range(0, ROWS - 1));
      if (pick < 42) begin
         // plenty of newlines so the screen scrolls several times
         if ($urandom_range(0, 2) == 0) c.char_code = NEWLINE_CODE;
      end else if (pick < 72) begin
         c.cmd = CMD_READ;
         aim = $urandom_range(0, 3);
         // bias reads to the cursor line and the bottom line
         if (aim == 0) c.row = ROW_IN_W'(sb.cur_row);
         else if (aim == 1) c.row = ROW_IN_W'(ROWS - 1);
      end else if (pick < 92) begin
         c.cmd = CMD_WRITE;
      end else if (pick < 96) begin
         c.cmd    = CMD_UNUSED;
         c.column = COL_IN_W'($urandom_range(0, 127));
         c.row    = ROW_IN_W'($urandom_range(0, 31));
      end else begin
         c.cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
         if ($urandom_range(0, 1)) c.column = COL_IN_W'($urandom_range(COLUMNS, 127));
         else c.row = ROW_IN_W'($urandom_range(ROWS, 31));
      end
      return c;
   endfunction

   // called at a rising edge; returns at the edge where the item was taken, or after the random gap
   task automatic send_command(command_type c);
      int unsigned gap;
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= c.cmd;
      req_chan.char_code  <= c.char_code;
      req_chan.cell_color <= c.cell_color;
      req_chan.column     <= c.column;
      req_chan.row        <= c.row;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_command(c);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle_block();
      req_chan.valid <= 1'b0;
      while (sb.awaited_status.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_text_color(logic [COLOR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_text_color(value);
      colours_used++;
   endtask

   initial begin
      logic [COLOR_W-1:0] phase_colour [PHASES];
      phase_colour[0] = 8'h00;
      phase_colour[1] = 8'hFF;
      phase_colour[2] = COLOR_W'($urandom_range(0, 255));
      phase_colour[3] = 8'h1E;
      phase_colour[4] = COLOR_W'($urandom_range(0, 255));

      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = '0;
      req_chan.char_code  = '0;
      req_chan.cell_color = '0;
      req_chan.column     = '0;
      req_chan.row        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners, out-of-range cells, the unused command and puts in the reset colour
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd0,  5'd0));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd79, 5'd24));
      send_command(make_command(CMD_WRITE, 8'hFF, 8'hFF, 7'd0,  5'd0));
      send_command(make_command(CMD_WRITE, 8'h00, 8'h00, 7'd79, 5'd24));
      send_command(make_command(CMD_WRITE, 8'h55, 8'hAA, 7'd80, 5'd0));
      send_command(make_command(CMD_WRITE, 8'hAA, 8'h55, 7'd127, 5'd31));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd0,  5'd0));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd79, 5'd24));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd80, 5'd0));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd0,  5'd25));
      send_command(make_command(CMD_READ,  8'hFF, 8'hFF, 7'd127, 5'd31));
      send_command(make_command(CMD_PUT,   8'h41, 8'h00, 7'd0,  5'd0));
      send_command(make_command(CMD_PUT,   8'h00, 8'hFF, 7'd127, 5'd31));
      send_command(make_command(CMD_PUT,   8'hFF, 8'h00, 7'd0,  5'd0));
      send_command(make_command(CMD_PUT,   NEWLINE_CODE, 8'h00, 7'd0, 5'd0));
      send_command(make_command(CMD_PUT,   NEWLINE_CODE, 8'h00, 7'd0, 5'd0));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd0,  5'd0));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd2,  5'd0));
      send_command(make_command(CMD_READ,  8'h00, 8'h00, 7'd3,  5'd0));
      send_command(make_command(CMD_UNUSED, 8'hFF, 8'hFF, 7'd127, 5'd31));
      send_command(make_command(CMD_UNUSED, 8'h00, 8'h00, 7'd0, 5'd0));
      settle_block();

      for (int p = 0; p < PHASES; p++) begin
         write_text_color(phase_colour[p]);
         burst_mode = (p == 3);
         repeat (PHASE_ITEMS) send_command(random_command());
         settle_block();
      end
      burst_mode = 1'b0;

      $display("summary: %0d items in %0d text colours, %0d results checked, %0d scrolls",
               items_sent, colours_used, sb.checked, sb.scrolls);
      if (sb.failures == 0 && sb.awaited_status.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
